FILE: sv/adpcm_sp_pkg.sv
// Shared types, codes, constants and tables of the ADPCM sample player.
package adpcm_sp_pkg;

  localparam int ROM_ADDR_BITS = 24;
  localparam logic [23:0] ROM_ADDR_MASK = (ROM_ADDR_BITS >= 24) ? 24'hFF_FFFF :
                                          24'((64'd1 << ROM_ADDR_BITS) - 64'd1);

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int ROM_SUM_W   = 26;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  localparam logic [2:0] OFF_START_LO  = 3'd0;
  localparam logic [2:0] OFF_START_MID = 3'd1;
  localparam logic [2:0] OFF_START_HI  = 3'd2;
  localparam logic [2:0] OFF_END_LO    = 3'd3;
  localparam logic [2:0] OFF_END_MID   = 3'd4;
  localparam logic [2:0] OFF_END_HI    = 3'd5;
  localparam logic [2:0] OFF_GO        = 3'd6;

  localparam logic [CFG_INDEX_W-1:0] CFG_BANK   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP   = 2'd2;

  localparam logic [6:0]         VOLUME_RESET = 7'd100;
  localparam logic signed [11:0] PRED_INIT    = -12'sd2;
  localparam logic signed [11:0] PRED_MAX     = 12'sd2047;
  localparam logic signed [11:0] PRED_MIN     = -12'sd2048;
  localparam logic [5:0]         STEP_MAX     = 6'd48;

  // floor(2^24 / 25); quotient estimate is at most one low
  localparam logic [19:0] RECIP_25   = 20'd671088;
  localparam int          RECIP_SHIFT = 24;
  localparam logic [15:0] SAMPLE_POS_LIMIT = 16'd32767;
  localparam logic [15:0] SAMPLE_NEG_LIMIT = 16'd32768;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] rom_byte;
  } item_t;

  typedef struct packed {
    logic [23:0] rom_bank;
    logic [6:0]  volume_percent;
    logic        loop_enable;
  } cfg_t;

  typedef struct packed {
    logic [17:0] mag;
    logic        neg;
    logic        is_playing;
    logic [23:0] rom_address;
  } s1_t;

  typedef struct packed {
    logic [19:0] x;
    logic [15:0] q_est;
    logic        neg;
    logic        is_playing;
    logic [23:0] rom_address;
  } s2_t;

  typedef struct packed {
    logic [15:0] sample_out;
    logic        is_playing;
    logic [23:0] rom_address;
  } out_t;

  function automatic logic [10:0] step_size(input logic [5:0] idx);
    logic [10:0] v;
    case (idx)
      6'd0:  v = 11'd16;   6'd1:  v = 11'd17;   6'd2:  v = 11'd19;   6'd3:  v = 11'd21;
      6'd4:  v = 11'd23;   6'd5:  v = 11'd25;   6'd6:  v = 11'd28;   6'd7:  v = 11'd31;
      6'd8:  v = 11'd34;   6'd9:  v = 11'd37;   6'd10: v = 11'd41;   6'd11: v = 11'd45;
      6'd12: v = 11'd50;   6'd13: v = 11'd55;   6'd14: v = 11'd60;   6'd15: v = 11'd66;
      6'd16: v = 11'd73;   6'd17: v = 11'd80;   6'd18: v = 11'd88;   6'd19: v = 11'd97;
      6'd20: v = 11'd107;  6'd21: v = 11'd118;  6'd22: v = 11'd130;  6'd23: v = 11'd143;
      6'd24: v = 11'd157;  6'd25: v = 11'd173;  6'd26: v = 11'd190;  6'd27: v = 11'd209;
      6'd28: v = 11'd230;  6'd29: v = 11'd253;  6'd30: v = 11'd279;  6'd31: v = 11'd307;
      6'd32: v = 11'd337;  6'd33: v = 11'd371;  6'd34: v = 11'd408;  6'd35: v = 11'd449;
      6'd36: v = 11'd494;  6'd37: v = 11'd544;  6'd38: v = 11'd598;  6'd39: v = 11'd658;
      6'd40: v = 11'd724;  6'd41: v = 11'd796;  6'd42: v = 11'd876;  6'd43: v = 11'd963;
      6'd44: v = 11'd1060; 6'd45: v = 11'd1166; 6'd46: v = 11'd1282; 6'd47: v = 11'd1411;
      6'd48: v = 11'd1552;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] code);
    logic signed [4:0] v;
    case (code)
      3'd4:    v = 5'sd2;
      3'd5:    v = 5'sd4;
      3'd6:    v = 5'sd6;
      3'd7:    v = 5'sd8;
      default: v = -5'sd1;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/adpcm_sp_decode.sv
// Request decode, playback state and nibble decoder with the gain product stage.
module adpcm_sp_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  adpcm_sp_pkg::item_t item,
  input  adpcm_sp_pkg::cfg_t  cfg,
  output adpcm_sp_pkg::s1_t   s1_r
);

  localparam int ROM_SUM_W_L = adpcm_sp_pkg::ROM_SUM_W;

  logic [19:0]        start_r, start_nxt;
  logic [19:0]        end_r, end_nxt;
  logic               playing_r, playing_nxt;
  logic [19:0]        base_r, base_nxt;
  logic [20:0]        idx_r, idx_nxt;
  logic [21:0]        total_r, total_nxt;
  logic signed [11:0] pred_r, pred_nxt;
  logic [5:0]         step_r, step_nxt;

  logic [3:0]         nib;
  logic [10:0]        sv;
  logic [12:0]        dmag;
  logic signed [13:0] delta;
  logic signed [13:0] pred_sum;
  logic signed [11:0] pred_sat;
  logic signed [4:0]  adj;
  logic signed [7:0]  step_sum;
  logic [5:0]         step_clamp;
  logic [20:0]        idx_inc;
  logic               idx_end;
  logic [20:0]        span;
  logic               emit;
  logic [11:0]        pred_mag;
  logic [18:0]        prod;
  logic [ROM_SUM_W_L-1:0] rom_sum;

  assign nib  = idx_r[0] ? item.rom_byte[3:0] : item.rom_byte[7:4];
  assign sv   = adpcm_sp_pkg::step_size(step_r);
  assign dmag = 13'(sv >> 3) + (nib[2] ? 13'(sv) : 13'd0) +
                (nib[1] ? 13'(sv >> 1) : 13'd0) + (nib[0] ? 13'(sv >> 2) : 13'd0);
  assign delta    = nib[3] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
  assign pred_sum = $signed({{2{pred_r[11]}}, pred_r}) + delta;

  always_comb begin
    if (pred_sum > 14'sd2047) begin
      pred_sat = adpcm_sp_pkg::PRED_MAX;
    end else if (pred_sum < -14'sd2048) begin
      pred_sat = adpcm_sp_pkg::PRED_MIN;
    end else begin
      pred_sat = pred_sum[11:0];
    end
  end

  assign adj      = adpcm_sp_pkg::index_adjust(nib[2:0]);
  assign step_sum = $signed({2'b00, step_r}) + $signed({{3{adj[4]}}, adj});

  always_comb begin
    if (step_sum > 8'sd48) begin
      step_clamp = adpcm_sp_pkg::STEP_MAX;
    end else if (step_sum < 8'sd0) begin
      step_clamp = 6'd0;
    end else begin
      step_clamp = step_sum[5:0];
    end
  end

  assign idx_inc = idx_r + 21'd1;
  assign idx_end = ({1'b0, idx_inc} >= total_r);
  assign span    = 21'(end_r) - 21'(start_r) + 21'd1;

  always_comb begin
    start_nxt   = start_r;
    end_nxt     = end_r;
    playing_nxt = playing_r;
    base_nxt    = base_r;
    idx_nxt     = idx_r;
    total_nxt   = total_r;
    pred_nxt    = pred_r;
    step_nxt    = step_r;
    emit        = 1'b0;
    case (item.req_type)
      adpcm_sp_pkg::REQ_WRITE: begin
        case (item.reg_offset)
          adpcm_sp_pkg::OFF_START_LO:  start_nxt = {start_r[19:8], item.write_data};
          adpcm_sp_pkg::OFF_START_MID: start_nxt = {start_r[19:16], item.write_data,
                                                    start_r[7:0]};
          adpcm_sp_pkg::OFF_START_HI:  start_nxt = {item.write_data[3:0], start_r[15:0]};
          adpcm_sp_pkg::OFF_END_LO:    end_nxt   = {end_r[19:8], item.write_data};
          adpcm_sp_pkg::OFF_END_MID:   end_nxt   = {end_r[19:16], item.write_data,
                                                    end_r[7:0]};
          adpcm_sp_pkg::OFF_END_HI:    end_nxt   = {item.write_data[3:0], end_r[15:0]};
          adpcm_sp_pkg::OFF_GO: begin
            if (start_r < end_r) begin
              if (!playing_r) begin
                playing_nxt = 1'b1;
                base_nxt    = start_r;
                idx_nxt     = 21'd0;
                total_nxt   = {span, 1'b0};
                pred_nxt    = adpcm_sp_pkg::PRED_INIT;
                step_nxt    = 6'd0;
              end
            end else begin
              playing_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      adpcm_sp_pkg::REQ_TICK: begin
        if (playing_r) begin
          emit     = 1'b1;
          pred_nxt = pred_sat;
          step_nxt = step_clamp;
          idx_nxt  = idx_inc;
          if (idx_end) begin
            if (cfg.loop_enable) begin
              idx_nxt  = 21'd0;
              pred_nxt = adpcm_sp_pkg::PRED_INIT;
              step_nxt = 6'd0;
            end else begin
              playing_nxt = 1'b0;
            end
          end
        end
      end
      adpcm_sp_pkg::REQ_STOP: playing_nxt = 1'b0;
      default: ;
    endcase
  end

  assign pred_mag = pred_sat[11] ? 12'(-pred_sat) : 12'(pred_sat);
  assign prod     = 19'(pred_mag) * 19'(cfg.volume_percent);
  assign rom_sum  = ROM_SUM_W_L'(cfg.rom_bank) + ROM_SUM_W_L'(base_nxt) +
                    ROM_SUM_W_L'(idx_nxt[20:1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= 20'd0;
      end_r     <= 20'd0;
      playing_r <= 1'b0;
      base_r    <= 20'd0;
      idx_r     <= 21'd0;
      total_r   <= 22'd0;
      pred_r    <= adpcm_sp_pkg::PRED_INIT;
      step_r    <= 6'd0;
    end else if (en) begin
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      playing_r <= playing_nxt;
      base_r    <= base_nxt;
      idx_r     <= idx_nxt;
      total_r   <= total_nxt;
      pred_r    <= pred_nxt;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.mag         <= emit ? prod[17:0] : 18'd0;
      s1_r.neg         <= emit & pred_sat[11];
      s1_r.is_playing  <= playing_nxt;
      s1_r.rom_address <= rom_sum[23:0] & adpcm_sp_pkg::ROM_ADDR_MASK;
    end
  end

endmodule

FILE: sv/adpcm_sp_scale.sv
// Divide-by-25 reciprocal stage, quotient correction and output saturation register.
module adpcm_sp_scale (
  input  logic              clk,
  input  logic              en_recip,
  input  logic              en_out,
  input  adpcm_sp_pkg::s1_t s1,
  output adpcm_sp_pkg::out_t out_r
);

  adpcm_sp_pkg::s2_t s2_r;

  logic [19:0] x;
  logic [39:0] recip_prod;
  logic [20:0] q25;
  logic [20:0] rem;
  logic [15:0] q;
  logic [15:0] sample;

  // magnitude * 16 / 100 == (magnitude * 4) / 25
  assign x          = {s1.mag, 2'b00};
  assign recip_prod = 40'(x) * 40'(adpcm_sp_pkg::RECIP_25);

  always_ff @(posedge clk) begin
    if (en_recip) begin
      s2_r.x           <= x;
      s2_r.q_est       <= recip_prod[adpcm_sp_pkg::RECIP_SHIFT +: 16];
      s2_r.neg         <= s1.neg;
      s2_r.is_playing  <= s1.is_playing;
      s2_r.rom_address <= s1.rom_address;
    end
  end

  assign q25 = (21'(s2_r.q_est) << 4) + (21'(s2_r.q_est) << 3) + 21'(s2_r.q_est);
  assign rem = 21'(s2_r.x) - q25;
  assign q   = (rem >= 21'd25) ? s2_r.q_est + 16'd1 : s2_r.q_est;

  always_comb begin
    if (s2_r.neg) begin
      sample = (q > adpcm_sp_pkg::SAMPLE_NEG_LIMIT) ? adpcm_sp_pkg::SAMPLE_NEG_LIMIT : -q;
    end else begin
      sample = (q > adpcm_sp_pkg::SAMPLE_POS_LIMIT) ? adpcm_sp_pkg::SAMPLE_POS_LIMIT : q;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_r.sample_out  <= sample;
      out_r.is_playing  <= s2_r.is_playing;
      out_r.rom_address <= s2_r.rom_address;
    end
  end

endmodule

FILE: sv/adpcm_sample_player_top.sv
// Top level of the single-channel 4-bit ADPCM sample player.
//
// Input channel (in_*): one request per transfer: a register write, a sample
// tick carrying the ROM byte fetched at the last reported rom_address, or a
// stop. Result channel (out_*): exactly one result per request, in order,
// with the decoded sample (zero unless a tick while playing), the playing
// flag and the ROM address needed by the next tick.
// Configuration port (cfg_*): bank offset, volume and loop enable, written
// while no request is in flight.
// The result passes through the input register, decode/gain stage,
// reciprocal stage and output register. Throughput: one request per cycle
// while the receiver accepts results; the playback state loop closes within
// the decode stage.
// Reset clears the playback state, sets volume to 100 and empties the
// pipeline. When the receiver stalls, the output register holds its result
// and the earlier stages keep filling until each holds an item, then
// in_tready drops.
module adpcm_sample_player_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [adpcm_sp_pkg::IN_TUSER_W-1:0]   in_tuser,   // req_type
  input  logic [adpcm_sp_pkg::IN_TDATA_W-1:0]   in_tdata,   // reg_offset, write_data, rom_byte
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [adpcm_sp_pkg::OUT_TDATA_W-1:0]  out_tdata,  // sample_out, is_playing, rom_address
  input  logic                                  cfg_we,
  input  logic [adpcm_sp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [adpcm_sp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  adpcm_sp_pkg::cfg_t  cfg_r;
  adpcm_sp_pkg::item_t item_r;
  adpcm_sp_pkg::s1_t   s1;
  adpcm_sp_pkg::out_t  out_res;

  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = !v0_r || rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_bank       <= 24'd0;
      cfg_r.volume_percent <= adpcm_sp_pkg::VOLUME_RESET;
      cfg_r.loop_enable    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        adpcm_sp_pkg::CFG_BANK:   cfg_r.rom_bank       <= cfg_wdata[23:0];
        adpcm_sp_pkg::CFG_VOLUME: cfg_r.volume_percent <= cfg_wdata[6:0];
        adpcm_sp_pkg::CFG_LOOP:   cfg_r.loop_enable    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_tready) v0_r <= in_tvalid;
      if (rdy1)      v1_r <= v0_r;
      if (rdy2)      v2_r <= v1_r;
      if (rdy3)      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type   <= in_tuser;
      item_r.reg_offset <= in_tdata[2:0];
      item_r.write_data <= in_tdata[10:3];
      item_r.rom_byte   <= in_tdata[18:11];
    end
  end

  adpcm_sp_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (v0_r && rdy1),
    .item  (item_r),
    .cfg   (cfg_r),
    .s1_r  (s1)
  );

  adpcm_sp_scale u_scale (
    .clk      (clk),
    .en_recip (v1_r && rdy2),
    .en_out   (v2_r && rdy3),
    .s1       (s1),
    .out_r    (out_res)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = {7'd0, out_res.rom_address, out_res.is_playing, out_res.sample_out};

endmodule

FILE: sv/adpcm_sp_checker.sv
// Port-level checker for the ADPCM sample player and its bind to the top level.
module adpcm_sp_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [adpcm_sp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register is empty");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:41] == 7'd0)
    else $error("result padding bits not zero");

endmodule

bind adpcm_sample_player_top adpcm_sp_checker u_chk (.*);
